// ===== hw/rtl/hms_pkg.sv =====
// Shared types and constants of the histogram merge and statistics block.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package hms_pkg;

	localparam int CH_W = 5;
	localparam int BIN_W = 12;
	localparam int CNT_W = 32;
	localparam int EN_W = 44;
	localparam int S1_W = 56;
	localparam int S2_W = 68;
	localparam int WIDE_W = 128;
	localparam int DEN_W = 88;
	localparam int MEAN_W = 25;
	localparam int VAR_W = 30;
	localparam int OFF_W = 16;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_QUERY = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_NOP = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_REFUSED = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	// Operand pairs of the shared shift-add multiplier.
	localparam logic [1:0] MS_DEN = 2'd0;
	localparam logic [1:0] MS_PROD = 2'd1;
	localparam logic [1:0] MS_SQ = 2'd2;

	localparam logic DS_MEAN = 1'b0;
	localparam logic DS_VAR = 1'b1;

	localparam logic [4:0] DIV_MEAN_Q = 5'd20;
	localparam logic [4:0] DIV_VAR_Q = 5'd30;

	localparam logic [OFF_W-1:0] BASELINE_RST = 16'hF800;

	typedef struct packed {
		logic       accept;
		logic       add_post;
		logic       walk_issue;
		logic       clr_run;
		logic       set_empty;
		logic       mul_start;
		logic [1:0] mul_sel;
		logic       mul_cap;
		logic       div_start;
		logic       div_sel;
		logic       div_cap;
		logic       post;
	} dp_cmd_t;

	typedef struct packed {
		logic dec_add;
		logic dec_query;
		logic dec_clear;
		logic out_free;
		logic walk_last;
		logic pipe_empty;
		logic en_zero;
		logic mul_done;
		logic div_done;
		logic clr_last;
	} dp_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/hms_ctrl.sv =====
// Controller state machine of the histogram block: sequences adds, bin walks,
// multiplies, divides and clearing sweeps. Depends on hms_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hms_ctrl import hms_pkg::*; (
	input  wire      clk,
	input  wire      arst_n,
	input  wire      s_tvalid,
	output logic     s_tready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_ADD   = 4'd2;
	localparam logic [3:0] S_WALK  = 4'd3;
	localparam logic [3:0] S_DRAIN = 4'd4;
	localparam logic [3:0] S_MUL1  = 4'd5;
	localparam logic [3:0] S_MUL2  = 4'd6;
	localparam logic [3:0] S_MUL3  = 4'd7;
	localparam logic [3:0] S_DIV1  = 4'd8;
	localparam logic [3:0] S_DIV2  = 4'd9;
	localparam logic [3:0] S_OUT   = 4'd10;

	logic [3:0] state_q, state_d;
	logic post_clr_q, post_clr_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		post_clr_d = post_clr_q;
		cmd = '0;
		unique case (state_q)
			S_CLR: begin
				cmd.clr_run = 1'b1;
				if (stat.clr_last) begin
					state_d = post_clr_q ? S_OUT : S_IDLE;
				end
			end
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					if (stat.dec_add) begin
						state_d = S_ADD;
					end else if (stat.dec_query) begin
						state_d = S_WALK;
					end else if (stat.dec_clear) begin
						state_d = S_CLR;
						post_clr_d = 1'b1;
					end else begin
						state_d = S_OUT;
					end
				end
			end
			S_ADD: begin
				if (stat.out_free) begin
					cmd.add_post = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_WALK: begin
				cmd.walk_issue = 1'b1;
				if (stat.walk_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (stat.pipe_empty) begin
					if (stat.en_zero) begin
						cmd.set_empty = 1'b1;
						state_d = S_OUT;
					end else begin
						cmd.mul_start = 1'b1;
						cmd.mul_sel = MS_DEN;
						state_d = S_MUL1;
					end
				end
			end
			S_MUL1: begin
				if (stat.mul_done) begin
					cmd.mul_cap = 1'b1;
					cmd.mul_start = 1'b1;
					cmd.mul_sel = MS_PROD;
					state_d = S_MUL2;
				end
			end
			S_MUL2: begin
				if (stat.mul_done) begin
					cmd.mul_cap = 1'b1;
					cmd.mul_start = 1'b1;
					cmd.mul_sel = MS_SQ;
					state_d = S_MUL3;
				end
			end
			S_MUL3: begin
				if (stat.mul_done) begin
					cmd.mul_cap = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_sel = DS_MEAN;
					state_d = S_DIV1;
				end
			end
			S_DIV1: begin
				if (stat.div_done) begin
					cmd.div_cap = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_sel = DS_VAR;
					state_d = S_DIV2;
				end
			end
			S_DIV2: begin
				if (stat.div_done) begin
					cmd.div_cap = 1'b1;
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (stat.out_free) begin
					cmd.post = 1'b1;
					post_clr_d = 1'b0;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			post_clr_q <= 1'b0;
		end else begin
			state_q <= state_d;
			post_clr_q <= post_clr_d;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/hms_dp.sv =====
// Datapath of the histogram block: count memory, bin walk pipeline, shared
// shift-add multiplier, shared restoring divider and result register. Uses hms_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hms_dp import hms_pkg::*; #(
	parameter int NUM_CHANNELS = 32,
	parameter int NUM_BINS = 4096
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire  [1:0]   s_tuser,
	input  wire  [55:0]  s_tdata,
	input  wire          m_tready,
	output logic         m_tvalid,
	output logic [1:0]   m_tuser,
	output logic [103:0] m_tdata,
	input  wire          cfg_we,
	input  wire  [15:0]  cfg_wdata,
	input  dp_cmd_t      cmd,
	output dp_stat_t     stat
);

	localparam int DEPTH = NUM_CHANNELS * NUM_BINS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [CH_W:0] NCH = (CH_W + 1)'(NUM_CHANNELS);
	localparam logic [BIN_W:0] NBIN = (BIN_W + 1)'(NUM_BINS);
	localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NUM_BINS - 1);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

	logic [CNT_W-1:0] mem [DEPTH];
	logic [CNT_W-1:0] mem_rdata_q;
	logic [ADDR_W-1:0] mem_addr;
	logic [CNT_W-1:0] mem_wdata;
	logic mem_we, mem_re;

	logic [1:0] in_op;
	logic [CH_W-1:0] in_ch;
	logic [BIN_W-1:0] in_bin;
	logic [CNT_W-1:0] in_cnt;
	logic ch_bad, bin_bad;
	logic [ADDR_W-1:0] in_base, in_addr;

	logic [OFF_W-1:0] offset_q;
	logic [ADDR_W-1:0] base_q, addr_q, clr_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W:0] add_sum;

	logic [BIN_W-1:0] idx_q;
	logic [2*BIN_W-1:0] sq_q;
	logic v_s1, v_s2;
	logic [BIN_W-1:0] idx_s1;
	logic [2*BIN_W-1:0] sq_s1;
	logic [CNT_W-1:0] c_s2;
	logic [EN_W-1:0] p1_s2;
	logic [S1_W-1:0] p2_s2;
	logic [EN_W-1:0] en_q;
	logic [S1_W-1:0] s1_q;
	logic [S2_W-1:0] s2_q;

	logic [S1_W-1:0] mul_a_q;
	logic [WIDE_W-1:0] mul_b_q, mul_acc_q;
	logic [1:0] mul_sel_q;
	logic [WIDE_W-1:0] prod_q;
	logic [DEN_W-1:0] den_q;

	logic [WIDE_W-1:0] rem_q, dsh_q;
	logic [VAR_W-1:0] quo_q;
	logic [4:0] dcnt_q;
	logic chk_q, sat_q, div_sel_q, div_ge;

	logic [1:0] res_status_q;
	logic [EN_W-1:0] res_entries_q;
	logic signed [MEAN_W-1:0] res_mean_q, mean_v;
	logic [VAR_W-1:0] res_var_q;

	logic m_tvalid_q;
	logic [1:0] m_tuser_q;
	logic [103:0] m_tdata_q;

	// Input beat fields.
	assign in_op = s_tuser;
	assign in_ch = s_tdata[4:0];
	assign in_bin = s_tdata[16:5];
	assign in_cnt = s_tdata[48:17];
	assign ch_bad = {1'b0, in_ch} >= NCH;
	assign bin_bad = {1'b0, in_bin} >= NBIN;
	assign in_base = ADDR_W'(32'(in_ch) * 32'(NUM_BINS));
	assign in_addr = in_base + ADDR_W'(in_bin);

	assign add_sum = {1'b0, mem_rdata_q} + {1'b0, cnt_q};

	always_comb begin
		mem_addr = in_addr;
		mem_wdata = add_sum[CNT_W-1:0];
		mem_we = 1'b0;
		mem_re = 1'b0;
		if (cmd.clr_run) begin
			mem_addr = clr_q;
			mem_wdata = '0;
			mem_we = 1'b1;
		end else if (cmd.walk_issue) begin
			mem_addr = base_q + ADDR_W'(idx_q);
			mem_re = 1'b1;
		end else if (cmd.add_post) begin
			mem_addr = addr_q;
			mem_we = !add_sum[CNT_W];
		end else begin
			mem_re = cmd.accept && stat.dec_add;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata_q <= mem[mem_addr];
		end
	end

	assign stat.dec_add = (in_op == OP_ADD) && !ch_bad && !bin_bad;
	assign stat.dec_query = (in_op == OP_QUERY) && !ch_bad;
	assign stat.dec_clear = (in_op == OP_CLEAR);
	assign stat.out_free = !m_tvalid_q || m_tready;
	assign stat.walk_last = (idx_q == LAST_BIN);
	assign stat.pipe_empty = !v_s1 && !v_s2;
	assign stat.en_zero = (en_q == '0);
	assign stat.mul_done = (mul_a_q == '0);
	assign stat.div_done = !chk_q && (dcnt_q == '0);
	assign stat.clr_last = (clr_q == LAST_ADDR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= BASELINE_RST;
		end else if (cfg_we) begin
			offset_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.accept && stat.dec_clear) begin
			clr_q <= '0;
		end else if (cmd.clr_run) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			base_q <= in_base;
			addr_q <= in_addr;
			cnt_q <= in_cnt;
		end
	end

	// Bin walk: issue, memory read, products, accumulation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			idx_q <= '0;
			sq_q <= '0;
		end else begin
			v_s1 <= cmd.walk_issue;
			v_s2 <= v_s1;
			if (cmd.accept) begin
				idx_q <= '0;
				sq_q <= '0;
			end else if (cmd.walk_issue) begin
				idx_q <= idx_q + 1'b1;
				sq_q <= sq_q + (2*BIN_W)'({idx_q, 1'b1});
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		sq_s1 <= sq_q;
		c_s2 <= mem_rdata_q;
		p1_s2 <= EN_W'(idx_s1) * EN_W'(mem_rdata_q);
		p2_s2 <= S1_W'(sq_s1) * S1_W'(mem_rdata_q);
		if (cmd.accept) begin
			en_q <= '0;
			s1_q <= '0;
			s2_q <= '0;
		end else if (v_s2) begin
			en_q <= en_q + EN_W'(c_s2);
			s1_q <= s1_q + S1_W'(p1_s2);
			s2_q <= s2_q + S2_W'(p2_s2);
		end
	end

	// Shared shift-add multiplier, one multiplier bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_a_q <= '0;
		end else if (cmd.mul_start) begin
			case (cmd.mul_sel)
				MS_SQ: mul_a_q <= s1_q;
				default: mul_a_q <= S1_W'(en_q);
			endcase
		end else if (mul_a_q != '0) begin
			mul_a_q <= mul_a_q >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_start) begin
			mul_sel_q <= cmd.mul_sel;
			mul_acc_q <= '0;
			case (cmd.mul_sel)
				MS_DEN: mul_b_q <= WIDE_W'(en_q - 1'b1);
				MS_PROD: mul_b_q <= WIDE_W'(s2_q);
				default: mul_b_q <= WIDE_W'(s1_q);
			endcase
		end else if (mul_a_q != '0) begin
			if (mul_a_q[0]) begin
				mul_acc_q <= mul_acc_q + mul_b_q;
			end
			mul_b_q <= mul_b_q << 1;
		end
		if (cmd.mul_cap) begin
			case (mul_sel_q)
				MS_DEN: den_q <= mul_acc_q[DEN_W-1:0];
				MS_PROD: prod_q <= mul_acc_q;
				default: prod_q <= (prod_q - mul_acc_q) << 8;
			endcase
		end
	end

	// Shared restoring divider; the first step checks for saturation.
	assign div_ge = (rem_q >= dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_q <= 1'b0;
			dcnt_q <= '0;
		end else if (cmd.div_start) begin
			chk_q <= 1'b1;
			dcnt_q <= (cmd.div_sel == DS_VAR) ? DIV_VAR_Q : DIV_MEAN_Q;
		end else if (chk_q) begin
			chk_q <= 1'b0;
		end else if (dcnt_q != '0) begin
			dcnt_q <= dcnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			div_sel_q <= cmd.div_sel;
			quo_q <= '0;
			sat_q <= 1'b0;
			if (cmd.div_sel == DS_VAR) begin
				rem_q <= prod_q;
				dsh_q <= WIDE_W'(den_q) << DIV_VAR_Q;
			end else begin
				rem_q <= WIDE_W'({s1_q, 8'b0});
				dsh_q <= WIDE_W'(en_q) << DIV_MEAN_Q;
			end
		end else if (chk_q) begin
			sat_q <= div_ge;
			dsh_q <= dsh_q >> 1;
		end else if (dcnt_q != '0) begin
			if (div_ge) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q <= {quo_q[VAR_W-2:0], div_ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign mean_v = $signed({5'b0, quo_q[19:0]}) + $signed({offset_q[OFF_W-1], offset_q, 8'b0});

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			res_status_q <= ((in_op == OP_ADD || in_op == OP_QUERY) && ch_bad) ||
				(in_op == OP_ADD && bin_bad) ? ST_RANGE : ST_OK;
			res_entries_q <= '0;
			res_mean_q <= '0;
			res_var_q <= '0;
		end else if (cmd.set_empty) begin
			res_status_q <= ST_EMPTY;
		end else if (cmd.div_cap) begin
			if (div_sel_q == DS_MEAN) begin
				res_entries_q <= en_q;
				res_mean_q <= mean_v;
			end else if (en_q[EN_W-1:1] == '0) begin
				// A single entry has no spread.
				res_var_q <= '0;
			end else begin
				res_var_q <= sat_q ? '1 : quo_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.post || cmd.add_post) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.add_post) begin
			m_tuser_q <= add_sum[CNT_W] ? ST_REFUSED : ST_OK;
			m_tdata_q <= '0;
		end else if (cmd.post) begin
			m_tuser_q <= res_status_q;
			m_tdata_q <= {5'b0, res_var_q, res_mean_q, res_entries_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser = m_tuser_q;
	assign m_tdata = m_tdata_q;

endmodule
`default_nettype wire

// ===== hw/rtl/histogram_merge_stats.sv =====
// Add: the accepted beat reads the single-port count memory, then the sum, unless it
// overflows, is written back and the result posted once the output register is free; no new
// beat is taken before that write. Query: a one-bin-per-cycle walk, then the shift-add
// multiplier (up to 56 steps each) and the divider. Clear: one memory word zeroed per cycle.
// After reset the same clearing pass runs with s_tready low; offset resets to -2048.
// The result register lets a new beat be taken while a result waits on m_tready.
`timescale 1ns / 1ps
`default_nettype none
module histogram_merge_stats import hms_pkg::*; #(
	parameter int NUM_CHANNELS = 32,
	parameter int NUM_BINS = 4096
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	input  wire  [1:0]   s_tuser,   // op
	input  wire  [55:0]  s_tdata,   // channel, bin_index, count, zero fill
	output logic         m_tvalid,
	input  wire          m_tready,
	output logic [1:0]   m_tuser,   // status
	output logic [103:0] m_tdata,   // entries, mean_q8, variance_q8, zero fill
	input  wire          cfg_we,
	input  wire  [15:0]  cfg_wdata  // baseline_offset
);

	dp_cmd_t cmd;
	dp_stat_t stat;

	hms_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	hms_dp #(
		.NUM_CHANNELS (NUM_CHANNELS),
		.NUM_BINS     (NUM_BINS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tuser   (m_tuser),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.stat      (stat)
	);

	a_post_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.post || cmd.add_post) |-> stat.out_free)
		else $error("result posted while output register is held");

	a_idle_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> stat.pipe_empty)
		else $error("walk pipeline busy while taking a beat");

	a_clr_block: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_run |-> !s_tready)
		else $error("beat taken during clearing sweep");

	a_unit_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.mul_start && cmd.div_start))
		else $error("multiplier and divider started together");

endmodule
`default_nettype wire
